@@ sv/spm_pkg.sv @@
package spm_pkg;

	// Default sizes of the store and of the kept field widths.
	localparam int DEPTH_DEF       = 16;
	localparam int PRIO_BITS_DEF   = 8;
	localparam int HANDLE_BITS_DEF = 16;

	// Request kinds.
	localparam logic REQ_DELIVER = 1'b0;
	localparam logic REQ_CONSULT = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DELIVERED = 2'd0,
		ST_RETURNED  = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One request beat.
	typedef struct packed {
		logic        req_type;
		logic [7:0]  priority_req;
		logic [15:0] message_handle;
	} req_t;

	// One result beat.
	typedef struct packed {
		status_t     status;
		logic [15:0] out_handle;
		logic [7:0]  out_priority;
	} rsp_t;

	// Shift commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

@@ sv/stable_priority_mailbox.sv @@
// Bounded priority mailbox built as a sorted chain of DEPTH cells. A deliver request
// places its handle behind every stored entry of greater or equal priority; a consult
// request removes the head (highest priority, oldest among equals) or reports empty.
// A deliver into a full mailbox is dropped with status full. Every request accepted
// (start high while busy low) gives exactly one result beat, marked by done in the next
// cycle; busy never rises, so a new request may be issued in every cycle. The chain needs
// no search for this: all cells compare against the new priority in parallel and shift
// by one place in the same edge. Results cannot be
// stalled and must be captured in the cycle done is high. Priorities and handles keep
// their low PRIO_BITS and HANDLE_BITS bits; returned fields are zero unless a message
// is returned.
module stable_priority_mailbox #(
	parameter int DEPTH       = spm_pkg::DEPTH_DEF,
	parameter int PRIO_BITS   = spm_pkg::PRIO_BITS_DEF,
	parameter int HANDLE_BITS = spm_pkg::HANDLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spm_pkg::req_t req,
	output logic          done,
	output spm_pkg::rsp_t rsp
);
	import spm_pkg::*;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [PRIO_BITS-1:0]   new_prio;
	logic [HANDLE_BITS-1:0] new_handle;
	cell_ctl_t              ctl;
	rsp_t                   rsp_d;
	rsp_t                   rsp_q;
	logic                   done_q;

	logic                   cond_w   [DEPTH];
	logic                   occ_w    [DEPTH];
	logic [PRIO_BITS-1:0]   prio_w   [DEPTH];
	logic [HANDLE_BITS-1:0] handle_w [DEPTH];

	assign busy       = 1'b0;
	assign accept     = start && !busy;
	assign new_prio   = PRIO_BITS'(req.priority_req);
	assign new_handle = HANDLE_BITS'(req.message_handle);
	assign full       = occ_w[DEPTH-1];
	assign empty      = !occ_w[0];

	// Shift commands for the chain.
	always_comb begin
		ctl.ins = accept && (req.req_type == REQ_DELIVER) && !full;
		ctl.rem = accept && (req.req_type == REQ_CONSULT) && !empty;
	end

	// The chain of cells; cell 0 is the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   p_cond;
		logic                   p_occ;
		logic [PRIO_BITS-1:0]   p_prio;
		logic [HANDLE_BITS-1:0] p_handle;
		logic                   n_occ;
		logic [PRIO_BITS-1:0]   n_prio;
		logic [HANDLE_BITS-1:0] n_handle;

		if (i == 0) begin : g_head
			assign p_cond   = 1'b0;
			assign p_occ    = 1'b1;
			assign p_prio   = new_prio;
			assign p_handle = new_handle;
		end else begin : g_mid
			assign p_cond   = cond_w[i-1];
			assign p_occ    = occ_w[i-1];
			assign p_prio   = prio_w[i-1];
			assign p_handle = handle_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_occ    = 1'b0;
			assign n_prio   = prio_w[i];
			assign n_handle = handle_w[i];
		end else begin : g_body
			assign n_occ    = occ_w[i+1];
			assign n_prio   = prio_w[i+1];
			assign n_handle = handle_w[i+1];
		end

		spm_cell #(
			.PRIO_BITS   (PRIO_BITS),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_prio    (new_prio),
			.new_handle  (new_handle),
			.prev_cond   (p_cond),
			.prev_occ    (p_occ),
			.prev_prio   (p_prio),
			.prev_handle (p_handle),
			.next_occ    (n_occ),
			.next_prio   (n_prio),
			.next_handle (n_handle),
			.cond        (cond_w[i]),
			.occ         (occ_w[i]),
			.prio        (prio_w[i]),
			.handle      (handle_w[i])
		);
	end

	// Result of the request being accepted, taken from the head and tail cells.
	always_comb begin
		rsp_d.status       = ST_DELIVERED;
		rsp_d.out_handle   = '0;
		rsp_d.out_priority = '0;
		if (req.req_type == REQ_DELIVER) begin
			rsp_d.status = full ? ST_FULL : ST_DELIVERED;
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status       = ST_RETURNED;
			rsp_d.out_handle   = 16'(handle_w[0]);
			rsp_d.out_priority = 8'(prio_w[0]);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ sv/spm_cell.sv @@
module spm_cell #(
	parameter int PRIO_BITS   = spm_pkg::PRIO_BITS_DEF,
	parameter int HANDLE_BITS = spm_pkg::HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spm_pkg::cell_ctl_t     ctl,
	input  logic [PRIO_BITS-1:0]   new_prio,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic                   prev_cond,
	input  logic                   prev_occ,
	input  logic [PRIO_BITS-1:0]   prev_prio,
	input  logic [HANDLE_BITS-1:0] prev_handle,
	input  logic                   next_occ,
	input  logic [PRIO_BITS-1:0]   next_prio,
	input  logic [HANDLE_BITS-1:0] next_handle,
	output logic                   cond,
	output logic                   occ,
	output logic [PRIO_BITS-1:0]   prio,
	output logic [HANDLE_BITS-1:0] handle
);
	import spm_pkg::*;

	logic                   occ_q;
	logic [PRIO_BITS-1:0]   prio_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// The new entry belongs at or behind this cell when the cell is free or holds a
	// strictly lower priority. Because the chain is sorted this flag is monotonic.
	assign cond = !occ_q || (prio_q < new_prio);

	// Occupancy forms a thermometer code of the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.ins) begin
			occ_q <= prev_occ;
		end else if (ctl.rem) begin
			occ_q <= next_occ;
		end
	end

	// Insert: the first cell with the flag set takes the new entry, the cells after it
	// take their upstream neighbor. Remove: every cell takes its downstream neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_cond) begin
				prio_q   <= prev_prio;
				handle_q <= prev_handle;
			end else if (cond) begin
				prio_q   <= new_prio;
				handle_q <= new_handle;
			end
		end else if (ctl.rem) begin
			prio_q   <= next_prio;
			handle_q <= next_handle;
		end
	end

	assign occ    = occ_q;
	assign prio   = prio_q;
	assign handle = handle_q;

endmodule

@@ sv/spm_checker.sv @@
module spm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input spm_pkg::req_t req,
	input logic          done,
	input spm_pkg::rsp_t rsp
);
	import spm_pkg::*;

	// Every accepted request gives a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && start && !busy) |=> done)
		else $error("accepted request gave no result beat");

	// No result beat appears without a request before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without a request");

	// Only a returned message carries a handle and a priority.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_RETURNED) |-> (rsp.out_handle == '0 && rsp.out_priority == '0))
		else $error("nonzero fields on a result without a message");

	// A deliver can never be answered as empty and a consult never as delivered or full.
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && start && !busy) |=>
		(($past(req.req_type) == REQ_DELIVER) ==
		 (rsp.status == ST_DELIVERED || rsp.status == ST_FULL)))
		else $error("result status does not match the request kind");

endmodule

bind stable_priority_mailbox spm_checker u_spm_checker (.*);
